[rtl/core/assert_macros.svh]
// Assertion helpers. Define ASSERT_OFF to drop all checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(lbl, clk_s, rstn_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk_s, rstn_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) !(expr)) \
    else $error("forbidden condition");
`else
`define ASSERT_IMPL(lbl, clk_s, rstn_s, prop)
`define ASSERT_NEVER(lbl, clk_s, rstn_s, expr)
`endif
`endif

[rtl/core/ddo_pkg.sv]
`default_nettype none
package ddo_pkg;

  localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
  localparam logic [32:0] PI_Q30      = 33'd3373259426;
  localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
  localparam logic [33:0] GAIN_Q30    = 34'd652032874;
  localparam int unsigned MAX_STEPS   = 30;

  // CORDIC arctangent table, Q30
  function automatic logic [29:0] arc_q30(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // Signed saturation of a magnitude quotient; ovf marks a quotient of 2^32 or more
  function automatic logic [31:0] sat_quot(input logic neg, input logic zero,
                                           input logic ovf, input logic [31:0] q);
    logic [31:0] v;
    if (zero) v = 32'd0;
    else if (neg) v = (ovf || q[31]) ? 32'h8000_0000 : (32'd0 - q);
    else v = (ovf || q >= 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
    return v;
  endfunction

  // Signed saturation of a 47-bit magnitude
  function automatic logic [31:0] sat_wide(input logic neg, input logic [46:0] m);
    logic [31:0] v;
    if (neg) v = (m >= 47'h0_8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
    else v = (m >= 47'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    return v;
  endfunction

endpackage
`default_nettype wire

[rtl/core/differential_drive_odometry_core.sv]
`default_nettype none
// Differential-drive kinematics and odometry, all values signed Q16.16.
// A command transfer (in_tuser = 0) stores the target speed and turn rate and
// restarts the time since the last command; it produces no result. A tick
// transfer (in_tuser = 1) advances that time, forms the two wheel setpoints
// (zero once the time exceeds the timeout register), turns the measured wheel
// speeds into body speeds and integrates heading, x and y, then posts one
// result. No new item is accepted until that result is loaded. A tick's time
// goes to three 32-step restoring divisions on one shared divider, one shared
// 34x33 multiplier that serves all products, the angle reduction and the
// CORDIC rotation, whose steps are capped at 30.
// in_tready is high only between ticks. A finished result sits in the output
// register until taken, so a new item can be accepted meanwhile; a following
// tick then holds in its last state until the output register frees up.
module differential_drive_odometry_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  // [31:0] target_linear, [63:32] target_angular, [95:64] measured_first_wheel,
  // [127:96] measured_second_wheel, [143:128] step_seconds
  input  wire logic [143:0] in_tdata,
  // [0] kind
  input  wire logic         in_tuser,
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  // [31:0] first_wheel_setpoint, [63:32] second_wheel_setpoint,
  // [95:64] body_linear, [127:96] body_angular, [159:128] pose_x,
  // [191:160] pose_y, [223:192] pose_heading
  output      logic [223:0] out_tdata,
  input  wire logic         cfg_wr_en,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [30:0]  cfg_data
);

  localparam int NSTEPS = (CORDIC_STEPS > int'(ddo_pkg::MAX_STEPS)) ?
                          int'(ddo_pkg::MAX_STEPS) : CORDIC_STEPS;
  localparam logic [4:0] LAST_STEP = 5'(NSTEPS - 1);

  localparam logic [1:0] REG_SEP = 2'd0;
  localparam logic [1:0] REG_RAD = 2'd1;
  localparam logic [1:0] REG_TMO = 2'd2;

  localparam logic [1:0] DS_SP1 = 2'd0;
  localparam logic [1:0] DS_SP2 = 2'd1;
  localparam logic [1:0] DS_VTH = 2'd2;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001, S_TURN = 16'h0002, S_SP1  = 16'h0004, S_SP2  = 16'h0008,
    S_DIV  = 16'h0010, S_VX   = 16'h0020, S_VTH  = 16'h0040, S_HD   = 16'h0080,
    S_RED  = 16'h0100, S_FOLD = 16'h0200, S_CORD = 16'h0400, S_XC   = 16'h0800,
    S_XT   = 16'h1000, S_YS   = 16'h2000, S_YT   = 16'h4000, S_DONE = 16'h8000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [30:0] sep_r, rad_r, tmo_r;

  // held command and pose
  logic [31:0] lin_r, ang_r, tsc_r, px_r, py_r, hd_r;
  logic [31:0] lin_nxt, ang_nxt, tsc_nxt, px_nxt, py_nxt, hd_nxt;

  // tick operands and intermediates
  logic [31:0] m1_r, m2_r, m1_nxt, m2_nxt;
  logic [15:0] dt_r, dt_nxt;
  logic        live_r, live_nxt;
  logic signed [63:0] turn_r, turn_nxt;
  logic [31:0] sp1_r, sp2_r, vx_r, vth_r, sp1_nxt, sp2_nxt, vx_nxt, vth_nxt;
  logic signed [33:0] t_r, t_nxt;

  // divider
  logic [31:0] drem_r, dq_r, dden_r, drem_nxt, dq_nxt, dden_nxt;
  logic        dneg_r, dzero_r, dovf_r, dneg_nxt, dzero_nxt, dovf_nxt;
  logic [4:0]  dcnt_r, dcnt_nxt;
  logic [1:0]  dsel_r, dsel_nxt;

  // angle reduction and CORDIC
  logic [45:0] red_r, red_nxt;
  logic        rneg_r, rneg_nxt;
  logic [3:0]  rk_r, rk_nxt;
  logic signed [33:0] cx_r, cy_r, cx_nxt, cy_nxt;
  logic signed [34:0] cz_r, cz_nxt;
  logic        flip_r, flip_nxt;
  logic [4:0]  ci_r, ci_nxt;

  // output register
  logic         ovld_r, ovld_nxt;
  logic [223:0] odat_r, odat_nxt;

  // shared multiplier
  logic signed [33:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [66:0] prod;

  logic [32:0] tsc_sum;
  logic signed [32:0] wsum, wdiff;
  logic [32:0] wsum_mag, wdiff_mag;
  logic signed [63:0] lin_ext, num;
  logic [63:0] num_mag;
  logic [32:0] dshift;
  logic        dge;
  logic [31:0] q_step, rem_step, dres;
  logic [46:0] red_cmp;
  logic [33:0] r0;
  logic signed [34:0] r1, r2;
  logic        fl;
  logic signed [33:0] cs_sel;
  logic signed [31:0] hd_sum;
  logic [31:0] hd_mag;
  logic in_fire, out_fire;

  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = ovld_r && out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovld_r;
  assign out_tdata  = odat_r;

  assign wsum      = $signed({m1_r[31], m1_r}) + $signed({m2_r[31], m2_r});
  assign wdiff     = $signed({m1_r[31], m1_r}) - $signed({m2_r[31], m2_r});
  assign wsum_mag  = wsum[32] ? 33'(-wsum) : 33'(wsum);
  assign wdiff_mag = wdiff[32] ? 33'(-wdiff) : 33'(wdiff);
  assign lin_ext   = $signed({{15{lin_r[31]}}, lin_r, 17'd0});
  assign num       = state_r == S_SP2 ? lin_ext - turn_r : lin_ext + turn_r;
  assign num_mag   = num[63] ? 64'(-num) : 64'(num);
  assign cs_sel    = state_r == S_XC ? (flip_r ? -cx_r : cx_r)
                                     : (flip_r ? -cy_r : cy_r);

  // Pick the operands of the one multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_TURN: begin
        mul_a = 34'($signed(ang_r));
        mul_b = $signed({2'b00, sep_r});
      end
      S_VX: begin
        mul_a = $signed({1'b0, wsum_mag});
        mul_b = $signed({2'b00, rad_r});
      end
      S_VTH: begin
        mul_a = $signed({1'b0, wdiff_mag});
        mul_b = $signed({2'b00, rad_r});
      end
      S_HD: begin
        mul_a = 34'($signed(vth_r));
        mul_b = $signed({17'd0, dt_r});
      end
      S_XC, S_YS: begin
        mul_a = cs_sel;
        mul_b = 33'($signed(vx_r));
      end
      S_XT, S_YT: begin
        mul_a = t_r;
        mul_b = $signed({17'd0, dt_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign prod = mul_a * mul_b;

  // One restoring divider step
  assign dshift   = {drem_r, dq_r[31]};
  assign dge      = dshift >= {1'b0, dden_r};
  assign rem_step = dge ? 32'(dshift - {1'b0, dden_r}) : dshift[31:0];
  assign q_step   = {dq_r[30:0], dge};
  assign dres     = ddo_pkg::sat_quot(dneg_r, dzero_r, dovf_r, q_step);

  assign tsc_sum = {1'b0, tsc_r} + {17'd0, in_tdata[143:128]};
  assign hd_sum  = $signed(hd_r) + $signed(prod[47:16]);
  assign hd_mag  = hd_sum[31] ? 32'(-hd_sum) : 32'(hd_sum);
  assign red_cmp = {14'd0, ddo_pkg::TWO_PI_Q30} << rk_r;

  // Put the reduced angle into (-pi, pi], then fold into [-pi/2, pi/2]
  always_comb begin
    r0 = (rneg_r && red_r[32:0] != 33'd0)
       ? 34'({1'b0, ddo_pkg::TWO_PI_Q30} - {1'b0, red_r[32:0]})
       : {1'b0, red_r[32:0]};
    r1 = $signed({1'b0, r0});
    if (r1 > $signed({2'b00, ddo_pkg::PI_Q30}))
      r1 = r1 - $signed({2'b00, ddo_pkg::TWO_PI_Q30});
    fl = 1'b0;
    r2 = r1;
    if (r1 > $signed({2'b00, ddo_pkg::HALF_PI_Q30})) begin
      r2 = r1 - $signed({2'b00, ddo_pkg::PI_Q30});
      fl = 1'b1;
    end else if (r1 < -$signed({2'b00, ddo_pkg::HALF_PI_Q30})) begin
      r2 = r1 + $signed({2'b00, ddo_pkg::PI_Q30});
      fl = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    lin_nxt = lin_r;   ang_nxt = ang_r;   tsc_nxt = tsc_r;
    px_nxt = px_r;     py_nxt = py_r;     hd_nxt = hd_r;
    m1_nxt = m1_r;     m2_nxt = m2_r;     dt_nxt = dt_r;   live_nxt = live_r;
    turn_nxt = turn_r; sp1_nxt = sp1_r;   sp2_nxt = sp2_r;
    vx_nxt = vx_r;     vth_nxt = vth_r;   t_nxt = t_r;
    drem_nxt = drem_r; dq_nxt = dq_r;     dden_nxt = dden_r;
    dneg_nxt = dneg_r; dzero_nxt = dzero_r; dovf_nxt = dovf_r;
    dcnt_nxt = dcnt_r; dsel_nxt = dsel_r;
    red_nxt = red_r;   rneg_nxt = rneg_r; rk_nxt = rk_r;
    cx_nxt = cx_r;     cy_nxt = cy_r;     cz_nxt = cz_r;
    flip_nxt = flip_r; ci_nxt = ci_r;
    ovld_nxt = out_fire ? 1'b0 : ovld_r;
    odat_nxt = odat_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (!in_tuser) begin
            lin_nxt = in_tdata[31:0];
            ang_nxt = in_tdata[63:32];
            tsc_nxt = '0;
          end else begin
            tsc_nxt  = tsc_sum[32] ? 32'hFFFF_FFFF : tsc_sum[31:0];
            live_nxt = tsc_nxt <= {1'b0, tmo_r};
            m1_nxt   = in_tdata[95:64];
            m2_nxt   = in_tdata[127:96];
            dt_nxt   = in_tdata[143:128];
            state_nxt = S_TURN;
          end
        end
      end
      S_TURN: begin
        turn_nxt  = prod[63:0];
        state_nxt = S_SP1;
      end
      S_SP1, S_SP2, S_VTH: begin
        // Load the divider: magnitude, sign and overflow of the quotient
        if (state_r == S_VTH) begin
          drem_nxt  = prod[63:32];
          dq_nxt    = prod[31:0];
          dden_nxt  = {1'b0, sep_r};
          dneg_nxt  = wdiff[32];
          dzero_nxt = prod[63:0] == 64'd0;
          dovf_nxt  = prod[63:32] >= {1'b0, sep_r};
          dsel_nxt  = DS_VTH;
        end else begin
          drem_nxt  = num_mag[63:32];
          dq_nxt    = num_mag[31:0];
          dden_nxt  = {rad_r, 1'b0};
          dneg_nxt  = num[63];
          dzero_nxt = num_mag == 64'd0;
          dovf_nxt  = num_mag[63:32] >= {rad_r, 1'b0};
          dsel_nxt  = state_r == S_SP1 ? DS_SP1 : DS_SP2;
        end
        dcnt_nxt  = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        drem_nxt = rem_step;
        dq_nxt   = q_step;
        dcnt_nxt = dcnt_r + 5'd1;
        if (dcnt_r == 5'd31) begin
          unique case (dsel_r)
            DS_SP1: begin
              sp1_nxt = dres;
              state_nxt = S_SP2;
            end
            DS_SP2: begin
              sp2_nxt = dres;
              state_nxt = S_VX;
            end
            DS_VTH: begin
              vth_nxt = dres;
              state_nxt = S_HD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_VX: begin
        vx_nxt    = ddo_pkg::sat_wide(wsum[32], prod[63:17]);
        state_nxt = S_VTH;
      end
      S_HD: begin
        hd_nxt    = hd_sum;
        red_nxt   = {hd_mag, 14'd0};
        rneg_nxt  = hd_sum[31];
        rk_nxt    = 4'd13;
        state_nxt = S_RED;
      end
      S_RED: begin
        // Subtract 2*pi scaled by a falling power of two
        if ({1'b0, red_r} >= red_cmp) red_nxt = 46'({1'b0, red_r} - red_cmp);
        rk_nxt = rk_r - 4'd1;
        if (rk_r == 4'd0) state_nxt = S_FOLD;
      end
      S_FOLD: begin
        cx_nxt    = $signed(ddo_pkg::GAIN_Q30);
        cy_nxt    = '0;
        cz_nxt    = r2;
        flip_nxt  = fl;
        ci_nxt    = '0;
        state_nxt = S_CORD;
      end
      S_CORD: begin
        if (!cz_r[34]) begin
          cx_nxt = cx_r - (cy_r >>> ci_r);
          cy_nxt = cy_r + (cx_r >>> ci_r);
          cz_nxt = cz_r - $signed({5'd0, ddo_pkg::arc_q30(ci_r)});
        end else begin
          cx_nxt = cx_r + (cy_r >>> ci_r);
          cy_nxt = cy_r - (cx_r >>> ci_r);
          cz_nxt = cz_r + $signed({5'd0, ddo_pkg::arc_q30(ci_r)});
        end
        ci_nxt = ci_r + 5'd1;
        if (ci_r == LAST_STEP) state_nxt = S_XC;
      end
      S_XC, S_YS: begin
        t_nxt     = prod[63:30];
        state_nxt = state_r == S_XC ? S_XT : S_YT;
      end
      S_XT: begin
        px_nxt    = px_r + prod[47:16];
        state_nxt = S_YS;
      end
      S_YT: begin
        py_nxt    = py_r + prod[47:16];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Hold until the output register is free
        if (!ovld_r || out_tready) begin
          ovld_nxt  = 1'b1;
          odat_nxt  = {hd_r, py_r, px_r, vth_r, vx_r,
                       live_r ? sp2_r : 32'd0, live_r ? sp1_r : 32'd0};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sep_r   <= 31'd13107;
      rad_r   <= 31'd2162;
      tmo_r   <= 31'd32768;
      lin_r   <= '0;
      ang_r   <= '0;
      tsc_r   <= 32'hFFFF_FFFF;
      px_r    <= '0;
      py_r    <= '0;
      hd_r    <= '0;
      ovld_r  <= 1'b0;
      live_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          REG_SEP: sep_r <= cfg_data;
          REG_RAD: rad_r <= cfg_data;
          REG_TMO: tmo_r <= cfg_data;
          default: ;
        endcase
      end
      lin_r  <= lin_nxt;
      ang_r  <= ang_nxt;
      tsc_r  <= tsc_nxt;
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      hd_r   <= hd_nxt;
      ovld_r <= ovld_nxt;
      live_r <= live_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m1_r <= m1_nxt;   m2_r <= m2_nxt;   dt_r <= dt_nxt;
    turn_r <= turn_nxt;
    sp1_r <= sp1_nxt; sp2_r <= sp2_nxt; vx_r <= vx_nxt; vth_r <= vth_nxt;
    t_r <= t_nxt;
    drem_r <= drem_nxt; dq_r <= dq_nxt; dden_r <= dden_nxt;
    dneg_r <= dneg_nxt; dzero_r <= dzero_nxt; dovf_r <= dovf_nxt;
    dcnt_r <= dcnt_nxt; dsel_r <= dsel_nxt;
    red_r <= red_nxt; rneg_r <= rneg_nxt; rk_r <= rk_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; cz_r <= cz_nxt;
    flip_r <= flip_nxt; ci_r <= ci_nxt;
    odat_r <= odat_nxt;
  end

`include "assert_macros.svh"

  // A command transfer never produces a result
  `ASSERT_IMPL(a_cmd_no_result, clk, rst_n, (in_fire && !in_tuser && !ovld_r) |=> !ovld_r)
  // A tick transfer starts the sequencer and drops ready
  `ASSERT_IMPL(a_tick_busy, clk, rst_n, (in_fire && in_tuser) |=> (state_r == S_TURN && !in_tready))
  // Stale commands give zero setpoints
  `ASSERT_IMPL(a_timeout_zero, clk, rst_n, ($rose(ovld_r) && !live_r) |-> (odat_r[63:0] == 64'd0))
  // A result is only loaded when leaving the final state
  `ASSERT_IMPL(a_load_done, clk, rst_n, $rose(ovld_r) |-> ($past(state_r) == S_DONE))

endmodule
`default_nettype wire
